// ===== rtl/core/asrc_pkg.sv =====
package asrc_pkg;

  // word buffer geometry
  localparam int MAX_LEN = 32;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int HEAD_N  = 5;
  localparam int ROOT_N  = 5;

  // back end scan: two slots per root, then one closing slot
  localparam logic [3:0] SLOT_FLUSH = 4'(2 * ROOT_N);

  // characters that the rules look at
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_CASE = 8'h20;
  localparam logic [7:0] CH_NONE = 8'h00;

  // prefix weight offsets
  localparam logic [5:0] PFX_RE    = 6'd10;
  localparam logic [5:0] PFX_UN    = 6'd20;
  localparam logic [5:0] PFX_NON   = 6'd30;
  localparam logic [5:0] PFX_MULTI = 6'd40;

  // suffix weight codes
  localparam logic [2:0] SFX_WHOLE = 3'd0;
  localparam logic [2:0] SFX_ONE   = 3'd1;
  localparam logic [2:0] SFX_TWO   = 3'd2;
  localparam logic [2:0] SFX_THREE = 3'd3;
  localparam logic [2:0] SFX_FOUR  = 3'd4;
  localparam logic [2:0] SFX_FIVE  = 3'd5;

  typedef struct packed {
    logic [7:0] ch;
    logic       word_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0] root_start;
    logic [5:0] root_end;
    logic [7:0] tail_char;
    logic [5:0] weight_code;
    logic       last;
  } out_item_t;

  // one root to try: exclusive end, replaced tail character, suffix code
  typedef struct packed {
    logic             ok;
    logic [LEN_W-1:0] rend;
    logic [7:0]       tail;
    logic [2:0]       code;
  } root_t;

  // a finished word as the back end needs it
  typedef struct packed {
    logic [MAX_LEN-1:0]      vowels;
    logic [HEAD_N-1:0][7:0]  head;
    logic [ROOT_N-1:0]       root_ok;
    root_t [ROOT_N-1:0]      roots;
  } job_t;

  function automatic logic is_vowel(input logic [7:0] c);
    logic [7:0] q;
    q = c | CH_CASE;
    return (q == "a") || (q == "e") || (q == "i") || (q == "o") || (q == "u") ||
           (q == "y");
  endfunction

endpackage

// ===== rtl/core/affix_strip_root_candidates_core.sv =====
// Root candidate generator for a spelling checker. Characters enter one per cycle on the
// in_ channel, unless in_stall is high, and build the word (up to MAX_LEN characters, the
// rest ignored); the transfer with word_end set closes the word, and its candidate roots
// (whole word with re, un, non or multi stripped, then the roots of the suffix rule picked
// by the last character, each as is and prefix stripped) leave on the out_ channel, the
// last one flagged. Only candidates holding a vowel are sent. A closed word waits in a
// two-entry queue; the back end scans each word in ten candidate slots and a closing slot,
// holding while the out_ side stalls, while characters of the next words keep entering
// one per cycle unless in_stall is high. in_stall rises while two closed words wait in the
// queue.
module affix_strip_root_candidates_core
  import asrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  logic q_full;
  logic q_push;
  job_t push_job;
  logic q_pop;
  logic q_valid;
  job_t q_job;

  // word collection and rule selection
  asrc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // closed words waiting for the back end
  asrc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // candidate scan and result register
  asrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

// ===== rtl/core/asrc_front.sv =====
module asrc_front
  import asrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  logic [LEN_W-1:0]       len_r, len_nxt, len_upd;
  logic [HEAD_N-1:0][7:0] head_r, head_nxt;
  logic [3:0][7:0]        tail_r, tail_nxt;
  logic [MAX_LEN-1:0]     vow_r, vow_nxt;
  logic                   accept;
  logic [3:0][7:0]        lc;
  logic [7:0]             c;
  root_t [ROOT_N-1:0]     roots;

  function automatic root_t mk_root(input logic [LEN_W-1:0] e, input logic [7:0] t,
                                    input logic [2:0] code);
    root_t r;
    r.ok   = 1'b1;
    r.rend = e;
    r.tail = t;
    r.code = code;
    return r;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && in_data.word_end;

  // buffer update with the incoming character
  always_comb begin
    len_upd  = len_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    vow_nxt  = vow_r;
    if (len_r < LEN_W'(MAX_LEN)) begin
      len_upd = len_r + LEN_W'(1);
      if (len_r < LEN_W'(HEAD_N)) begin
        head_nxt[len_r[2:0]] = in_data.ch;
      end
      tail_nxt = {tail_r[2:0], in_data.ch};
      vow_nxt[len_r[IDX_W-1:0]] = is_vowel(in_data.ch);
    end
    len_nxt = in_data.word_end ? '0 : len_upd;
  end

  // lower-cased last characters, zero before the word's start
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lc[i] = (len_upd > LEN_W'(i)) ? (tail_nxt[i] | CH_CASE) : CH_NONE;
    end
    c = tail_nxt[0];
  end

  // suffix rule chosen by the last character
  always_comb begin
    roots    = '0;
    roots[0] = mk_root(len_upd, CH_NONE, SFX_WHOLE);
    if (len_upd > LEN_W'(2)) begin
      if (c == CH_APOS) begin
        if (lc[1] == "s") begin
          roots[1] = mk_root(len_upd - LEN_W'(1), CH_NONE, SFX_TWO);
          roots[2] = mk_root(len_upd - LEN_W'(2), CH_NONE, SFX_THREE);
          if (lc[2] == "e") begin
            roots[3] = mk_root(len_upd - LEN_W'(3), CH_NONE, SFX_FOUR);
            if (lc[3] == "i") begin
              roots[4] = mk_root(len_upd - LEN_W'(3), "y", SFX_FIVE);
            end
          end
        end
      end else begin
        case (c | CH_CASE)
          "s": begin
            if (lc[1] == CH_APOS) begin
              roots[1] = mk_root(len_upd - LEN_W'(2), CH_NONE, SFX_THREE);
            end else if (!(lc[1] == "u" && lc[2] == "o") && lc[1] != "s") begin
              roots[1] = mk_root(len_upd - LEN_W'(1), CH_NONE, SFX_ONE);
              if (lc[1] == "g" && lc[2] == "n" && lc[3] == "i") begin
                roots[2] = mk_root(len_upd - LEN_W'(4), CH_NONE, SFX_ONE);
              end
              if (lc[1] == "e") begin
                roots[2] = mk_root(len_upd - LEN_W'(2), (lc[2] == "i") ? 8'("y") : CH_NONE,
                                   SFX_THREE);
              end
            end
          end
          "d": begin
            if (lc[1] == "e") begin
              if (lc[2] == "i") begin
                roots[1] = mk_root(len_upd - LEN_W'(2), "y", SFX_TWO);
              end else begin
                roots[1] = mk_root(len_upd - LEN_W'(1), CH_NONE, SFX_ONE);
                roots[2] = mk_root(len_upd - LEN_W'(2), CH_NONE, SFX_TWO);
              end
            end
          end
          "g": begin
            if (lc[1] == "n" && lc[2] == "i") begin
              roots[1] = mk_root(len_upd - LEN_W'(3), CH_NONE, SFX_ONE);
              roots[2] = mk_root(len_upd - LEN_W'(2), "e", SFX_TWO);
            end
          end
          "r": begin
            if (lc[1] == "e") begin
              if (lc[2] == "i") begin
                roots[1] = mk_root(len_upd - LEN_W'(2), "y", SFX_TWO);
              end else begin
                roots[1] = mk_root(len_upd - LEN_W'(2), CH_NONE, SFX_ONE);
              end
            end
          end
          "y": begin
            if (lc[1] == "l") begin
              roots[1] = mk_root(len_upd - LEN_W'(2), CH_NONE, SFX_ONE);
            end
          end
          "t": begin
            if (lc[1] == "s" && lc[2] == "e") begin
              roots[1] = mk_root(len_upd - LEN_W'(3), (lc[3] == "i") ? 8'("y") : CH_NONE,
                                 SFX_ONE);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // finished word snapshot
  always_comb begin
    q_job.vowels = vow_nxt;
    q_job.head   = head_nxt;
    q_job.roots  = roots;
    for (int i = 0; i < ROOT_N; i++) begin
      q_job.root_ok[i] = roots[i].ok;
    end
  end

  // word state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (accept) begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      vow_r  <= vow_nxt;
    end
  end

endmodule

// ===== rtl/core/asrc_queue.sv =====
module asrc_queue
  import asrc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output job_t q_job
);

  job_t       mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = mem_r[rd_r];

  // pointer and fill count
  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop)) else $error("word queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("word queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("word queue count out of range");

endmodule

// ===== rtl/core/asrc_back.sv =====
module asrc_back
  import asrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  logic [3:0]       slot_r, slot_nxt;
  logic             pend_v_r, pend_v_nxt;
  out_item_t        pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  logic [2:0]       ridx;
  root_t            root;
  logic             pfx_slot;
  logic [4:0][7:0]  pc;
  logic             pfx_hit;
  logic [2:0]       pfx_len;
  logic [5:0]       pfx_add;
  logic [2:0]       start;
  logic [LEN_W-1:0] hi;
  logic [MAX_LEN-1:0] mask;
  logic             has_vowel;
  logic             hit;
  logic             out_free;
  out_item_t        cand;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // root under test in this slot
  always_comb begin
    ridx     = (slot_r < SLOT_FLUSH) ? slot_r[3:1] : 3'd0;
    root     = q_job.roots[ridx];
    pfx_slot = slot_r[0];
  end

  // first root characters, lower-cased, with the tail replaced
  always_comb begin
    for (int i = 0; i < HEAD_N; i++) begin
      if (LEN_W'(i) < root.rend) begin
        if (LEN_W'(i) == root.rend - LEN_W'(1) && root.tail != CH_NONE) begin
          pc[i] = root.tail | CH_CASE;
        end else begin
          pc[i] = q_job.head[i] | CH_CASE;
        end
      end else begin
        pc[i] = CH_NONE;
      end
    end
  end

  // prefix detection
  always_comb begin
    pfx_hit = 1'b0;
    pfx_len = 3'd0;
    pfx_add = 6'd0;
    if (pc[0] == "r" && pc[1] == "e") begin
      pfx_hit = 1'b1;
      pfx_len = 3'd2;
      pfx_add = PFX_RE;
    end else if (pc[0] == "u" && pc[1] == "n") begin
      pfx_hit = 1'b1;
      pfx_len = 3'd2;
      pfx_add = PFX_UN;
    end else if (pc[0] == "n" && pc[1] == "o" && pc[2] == "n") begin
      pfx_hit = 1'b1;
      pfx_len = 3'd3;
      pfx_add = PFX_NON;
    end else if (pc[0] == "m" && pc[1] == "u" && pc[2] == "l" && pc[3] == "t" &&
                 pc[4] == "i") begin
      pfx_hit = 1'b1;
      pfx_len = 3'd5;
      pfx_add = PFX_MULTI;
    end
  end

  // vowel check over the candidate's characters
  always_comb begin
    start = pfx_slot ? pfx_len : 3'd0;
    hi    = (root.tail != CH_NONE && root.rend != '0) ? root.rend - LEN_W'(1) : root.rend;
    for (int i = 0; i < MAX_LEN; i++) begin
      mask[i] = (LEN_W'(i) >= LEN_W'(start)) && (LEN_W'(i) < hi);
    end
    has_vowel = (|(q_job.vowels & mask)) ||
                (root.tail != CH_NONE && root.rend > LEN_W'(start));
  end

  // candidate of this slot
  always_comb begin
    cand.root_start  = start;
    cand.root_end    = 6'(root.rend);
    cand.tail_char   = root.tail;
    cand.weight_code = {3'd0, root.code} + (pfx_slot ? pfx_add : 6'd0);
    cand.last        = 1'b0;
    hit = (slot_r < SLOT_FLUSH) && root.ok && has_vowel &&
          (pfx_slot ? pfx_hit : (root.code != SFX_WHOLE));
  end

  // scan sequencing; a hit waits in pend until the next hit or the closing slot
  always_comb begin
    slot_nxt      = slot_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    if (q_valid) begin
      if (slot_r == SLOT_FLUSH) begin
        if (!pend_v_r) begin
          slot_nxt = 4'd0;
          q_pop    = 1'b1;
        end else if (out_free) begin
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
          slot_nxt      = 4'd0;
          q_pop         = 1'b1;
        end
      end else if (!(hit && pend_v_r && !out_free)) begin
        slot_nxt = slot_r + 4'd1;
        if (hit) begin
          if (pend_v_r) begin
            out_nxt       = pend_r;
            out_valid_nxt = 1'b1;
          end
          pend_nxt   = cand;
          pend_v_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= 4'd0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_FLUSH) else $error("scan slot out of range");
  a_pop_at_close: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (slot_r == SLOT_FLUSH && !(pend_v_r && !out_free)))
    else $error("word retired before its closing slot");
  a_close_drains: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !pend_v_r) else $error("candidate left behind at word close");
  a_last_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && pend_v_r) |=> (out_valid_r && out_r.last))
    else $error("final candidate not marked last");

endmodule

// ===== verif/affix_strip_root_candidates_core_tb.sv =====
module affix_strip_root_candidates_core_tb;
  import asrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  in_item_t  in_data;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  logic      out_stall;

  affix_strip_root_candidates_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );

  // pending characters and expected candidates
  in_item_t  char_queue[$];
  out_item_t cand_queue[$];

  // predictor copy of the word state
  logic [7:0] pred_buf[MAX_LEN];
  int         pred_len;
  out_item_t  word_cands[$];

  int errors;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  bit stim_done;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic logic [7:0] lc(input logic [7:0] c);
    return c | CH_CASE;
  endfunction

  // character of a root with optional replaced tail, zero outside
  function automatic logic [7:0] root_ch(input int idx, input int rend, input logic [7:0] tail);
    if (idx < 0 || idx >= rend || idx >= MAX_LEN) return CH_NONE;
    if (idx == rend - 1 && tail != CH_NONE) return tail;
    return pred_buf[idx];
  endfunction

  function automatic logic [7:0] word_ch(input int idx, input int n);
    if (idx < 0 || idx >= n || idx >= MAX_LEN) return CH_NONE;
    return lc(pred_buf[idx]);
  endfunction

  function automatic void add_cand(input int s, input int rend, input logic [7:0] tail,
                                   input int code);
    bit vowel;
    logic [7:0] q;
    out_item_t o;
    vowel = 0;
    for (int i = s; i < rend; i++) begin
      q = lc(root_ch(i, rend, tail));
      if (q inside {"a", "e", "i", "o", "u", "y"}) vowel = 1;
    end
    if (!vowel || word_cands.size() >= 9) return;
    o.root_start = 3'(s);
    o.root_end = 6'(rend);
    o.tail_char = tail;
    o.weight_code = 6'(code);
    o.last = 1'b0;
    word_cands.push_back(o);
  endfunction

  // root as is, then with a prefix stripped
  function automatic void try_root(input int rend, input logic [7:0] tail, input int code);
    logic [7:0] c0;
    c0 = lc(root_ch(0, rend, tail));
    if (code != SFX_WHOLE) add_cand(0, rend, tail, code);
    if (c0 == "r") begin
      if (lc(root_ch(1, rend, tail)) == "e") add_cand(2, rend, tail, code + PFX_RE);
    end else if (c0 == "u") begin
      if (lc(root_ch(1, rend, tail)) == "n") add_cand(2, rend, tail, code + PFX_UN);
    end else if (c0 == "n") begin
      if (lc(root_ch(1, rend, tail)) == "o" && lc(root_ch(2, rend, tail)) == "n")
        add_cand(3, rend, tail, code + PFX_NON);
    end else if (c0 == "m") begin
      if (lc(root_ch(1, rend, tail)) == "u" && lc(root_ch(2, rend, tail)) == "l" &&
          lc(root_ch(3, rend, tail)) == "t" && lc(root_ch(4, rend, tail)) == "i")
        add_cand(5, rend, tail, code + PFX_MULTI);
    end
  endfunction

  function automatic void suffix_roots(input int n);
    logic [7:0] c, q;
    int j, k;
    c = pred_buf[n - 1];
    j = n - 2;
    k = n - 3;
    if (c == CH_APOS) begin
      if (word_ch(j, n) != "s") return;
      try_root(n - 1, CH_NONE, SFX_TWO);
      try_root(n - 2, CH_NONE, SFX_THREE);
      if (word_ch(k, n) == "e") begin
        try_root(n - 3, CH_NONE, SFX_FOUR);
        if (word_ch(k - 1, n) == "i") try_root(n - 3, "y", SFX_FIVE);
      end
    end else if (c == "S" || c == "s") begin
      q = word_ch(j, n);
      if (q == CH_APOS) begin
        try_root(j, CH_NONE, SFX_THREE);
        return;
      end
      if (q == "u" && word_ch(j - 1, n) == "o") return;
      if (q != "s") begin
        try_root(n - 1, CH_NONE, SFX_ONE);
        if (q == "g") begin
          if (word_ch(j - 1, n) == "n" && word_ch(j - 2, n) == "i")
            try_root(j - 2, CH_NONE, SFX_ONE);
          return;
        end
      end
      if (q != "e") return;
      if (word_ch(j - 1, n) == "i") try_root(j, "y", SFX_THREE);
      else try_root(j, CH_NONE, SFX_THREE);
    end else if (c == "D" || c == "d") begin
      if (word_ch(j, n) != "e") return;
      if (word_ch(j - 1, n) == "i") begin
        try_root(j, "y", SFX_TWO);
        return;
      end
      try_root(n - 1, CH_NONE, SFX_ONE);
      try_root(j, CH_NONE, SFX_TWO);
    end else if (c == "G" || c == "g") begin
      if (word_ch(j, n) != "n" || word_ch(k, n) != "i") return;
      try_root(k, CH_NONE, SFX_ONE);
      try_root(k + 1, "e", SFX_TWO);
    end else if (c == "R" || c == "r") begin
      if (word_ch(j, n) != "e") return;
      if (word_ch(j - 1, n) == "i") try_root(j, "y", SFX_TWO);
      else try_root(j, CH_NONE, SFX_ONE);
    end else if (c == "Y" || c == "y") begin
      if (word_ch(j, n) == "l") try_root(j, CH_NONE, SFX_ONE);
    end else if (c == "T" || c == "t") begin
      if (word_ch(j, n) != "s" || word_ch(k, n) != "e") return;
      if (word_ch(k - 1, n) == "i") try_root(k, "y", SFX_ONE);
      else try_root(k, CH_NONE, SFX_ONE);
    end
  endfunction

  // take one character transfer, queue candidates at word end
  function automatic void predict_char(input in_item_t it);
    int n;
    if (pred_len < MAX_LEN) begin
      pred_buf[pred_len] = it.ch;
      pred_len++;
    end
    if (!it.word_end) return;
    n = pred_len;
    pred_len = 0;
    word_cands.delete();
    try_root(n, CH_NONE, SFX_WHOLE);
    if (n > 2) suffix_roots(n);
    if (word_cands.size() > 0) word_cands[word_cands.size() - 1].last = 1'b1;
    foreach (word_cands[i]) cand_queue.push_back(word_cands[i]);
  endfunction

  function automatic logic [7:0] rand_case(input logic [7:0] c);
    return ($urandom_range(0, 3) == 0) ? (c & ~CH_CASE) : c;
  endfunction

  // queue a word; random case, end marked on the last character
  function automatic void push_word(input string w);
    in_item_t it;
    for (int i = 0; i < w.len(); i++) begin
      it.ch = rand_case(w[i]);
      it.word_end = (i == w.len() - 1);
      char_queue.push_back(it);
    end
  endfunction

  function automatic string random_word();
    string pfx[6] = '{"", "", "re", "un", "non", "multi"};
    string stem[8] = '{"walk", "hop", "cry", "bak", "ous", "strng", "dis", "l"};
    string sfx[22] = '{"", "'s", "s'", "s", "es", "ies", "ings", "d", "ed", "ied", "ing",
                       "er", "ier", "ly", "est", "iest", "ies'", "es'", "'", "ous", "g", "t"};
    string w;
    int n;
    w = {pfx[$urandom_range(0, 5)], stem[$urandom_range(0, 7)], sfx[$urandom_range(0, 21)]};
    // some noise characters of any nonzero value
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 6);
      w = "";
      for (int i = 0; i < n; i++) w = {w, string'(8'($urandom_range(1, 255)))};
    end
    return w;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (char_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_data <= char_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // input monitor and predictor, receiver stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_char(in_data);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // output monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (cand_queue.size() == 0) begin
        report($sformatf("unexpected candidate %p", out_data));
      end else begin
        e = cand_queue.pop_front();
        if (out_data.root_start != e.root_start)
          report($sformatf("root_start %0d exp %0d", out_data.root_start, e.root_start));
        if (out_data.root_end != e.root_end)
          report($sformatf("root_end %0d exp %0d", out_data.root_end, e.root_end));
        if (out_data.tail_char != e.tail_char)
          report($sformatf("tail_char %0h exp %0h", out_data.tail_char, e.tail_char));
        if (out_data.weight_code != e.weight_code)
          report($sformatf("weight_code %0d exp %0d", out_data.weight_code, e.weight_code));
        if (out_data.last != e.last)
          report($sformatf("last %0b exp %0b", out_data.last, e.last));
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else if (!stim_done || cand_queue.size() > 0) begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    string lng;
    in_item_t it;
    errors = 0;
    quiet_cycles = 0;
    stim_done = 0;
    pred_len = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed words: prefixes, each suffix, lone apostrophe, ous, zero byte, overlong
    push_word("rewalks");
    push_word("unhop's");
    push_word("nonbox'");
    push_word("multicries'");
    push_word("MULTIboxes'");
    push_word("famous");
    push_word("singings");
    push_word("bakeries");
    push_word("cried");
    push_word("baked");
    push_word("baking");
    push_word("tinier");
    push_word("walker");
    push_word("slowly");
    push_word("happiest");
    push_word("fastest");
    push_word("a");
    push_word("by");
    it.ch = 8'h00; it.word_end = 1'b0; char_queue.push_back(it);
    it.ch = 8'hff; it.word_end = 1'b0; char_queue.push_back(it);
    push_word("ed");
    lng = "";
    for (int i = 0; i < 40; i++) lng = {lng, "o"};
    push_word({lng, "s"});

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 59 : (ph == 3) ? 23 : 0;
      stall_pct = (ph == 2) ? 59 : (ph == 3) ? 23 : 0;
      for (int w = 0; w < 5; w++) push_word(random_word());
      while (char_queue.size() > 0) @(posedge clk);
    end
    idle_pct = 0;
    stall_pct = 0;
    stim_done = 1;
    while (in_valid || cand_queue.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
